// ----- rtl/tlic_pkg.sv -----
// Shared types, constants and helpers for the three-level inclusive cache tag model.
`default_nettype none
package tlic_pkg;

  localparam int L1_SETS = 4;
  localparam int L2_SETS = 8;
  localparam int L3_SETS = 16;

  localparam int STAMP_W = 64;
  localparam int CNT_W   = 4;
  localparam logic [CNT_W-1:0] HITS_MAX = 4'hF;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_IFETCH = 2'd3;

  typedef enum logic [1:0] {
    CACHE_L1D,
    CACHE_L1I,
    CACHE_L2,
    CACHE_L3
  } cache_e;

  // Advance a hit count, hold at the top.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == HITS_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tlic_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tlic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/three_level_inclusive_cache_model_top.sv -----
// Top level of the three-level inclusive write-back cache tag model.
// Flow: an L1 hit strobes its result after a single L1 set walk; every set walk reads
//   the ways in turn on the single tag RAM read port, and a miss chains L2/L3 walks,
//   back-invalidations and write-backs (a modify runs two steps back to back).
// Throughput: one item at a time; busy stays high until the last result has been strobed.
// Reset: asynchronous, active low; clears all valid bits, the use clock and the sequencer.
`default_nettype none
module three_level_inclusive_cache_model_top #(
  parameter int L1_WAYS    = 2,
  parameter int L2_WAYS    = 4,
  parameter int L3_WAYS    = 8,
  parameter int ADDR_WIDTH = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            op_i,
  input  wire logic [ADDR_WIDTH-1:0] addr_i,
  output logic                       result_valid_o,
  output logic                       instr_side_o,
  output logic                       l1_hit_o,
  output logic                       l1_evict_o,
  output logic [3:0]                 l2_hits_added_o,
  output logic                       l2_miss_o,
  output logic                       l2_evict_o,
  output logic [3:0]                 l3_hits_added_o,
  output logic                       l3_miss_o,
  output logic                       l3_evict_o,
  output logic                       last_o
);

  // Entry layout: all ways of all four caches share one tag RAM, indexed as
  // cache base + set * ways + way. Valid bits live in flops, so tag RAM
  // contents are only trusted behind a set valid bit and need no clearing pass.
  localparam int I_BASE  = tlic_pkg::L1_SETS * L1_WAYS;
  localparam int L2_BASE = 2 * I_BASE;
  localparam int L3_BASE = L2_BASE + tlic_pkg::L2_SETS * L2_WAYS;
  localparam int NENT    = L3_BASE + tlic_pkg::L3_SETS * L3_WAYS;
  localparam int IW      = $clog2(NENT);
  localparam int TW      = ADDR_WIDTH - 5;
  localparam int SW      = tlic_pkg::STAMP_W;
  localparam int EW      = 1 + TW + SW;
  localparam int MW12    = (L1_WAYS > L2_WAYS) ? L1_WAYS : L2_WAYS;
  localparam int MW      = (MW12 > L3_WAYS) ? MW12 : L3_WAYS;
  localparam int WCW     = $clog2(MW + 1);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_SCAN      = 5'd1;
  localparam logic [4:0] S_L1_LOOK   = 5'd2;
  localparam logic [4:0] S_L1_LOOK_R = 5'd3;
  localparam logic [4:0] S_L2_LOOK_R = 5'd4;
  localparam logic [4:0] S_L3_LOOK_R = 5'd5;
  localparam logic [4:0] S_PAIR      = 5'd6;
  localparam logic [4:0] S_PAIR_L2   = 5'd7;
  localparam logic [4:0] S_PAIR_L2R  = 5'd8;
  localparam logic [4:0] S_PAIR_NEXT = 5'd9;
  localparam logic [4:0] S_L2_PICK   = 5'd10;
  localparam logic [4:0] S_L2_PICK_R = 5'd11;
  localparam logic [4:0] S_L2_EV     = 5'd12;
  localparam logic [4:0] S_L2_FILL   = 5'd13;
  localparam logic [4:0] S_L1_PICK   = 5'd14;
  localparam logic [4:0] S_L1_PICK_R = 5'd15;
  localparam logic [4:0] S_L1_FILL   = 5'd16;
  localparam logic [4:0] S_INV_D     = 5'd17;
  localparam logic [4:0] S_INV_DR    = 5'd18;
  localparam logic [4:0] S_INV_I     = 5'd19;
  localparam logic [4:0] S_INV_IR    = 5'd20;
  localparam logic [4:0] S_WB        = 5'd21;
  localparam logic [4:0] S_WB_R      = 5'd22;
  localparam logic [4:0] S_EMIT      = 5'd23;

  // Index of the first way of the set that an address maps to in a cache.
  function automatic logic [IW-1:0] set_base(input tlic_pkg::cache_e c,
                                             input logic [ADDR_WIDTH-1:0] a);
    unique case (c)
      tlic_pkg::CACHE_L1D: set_base = IW'(a[4:3]) * IW'(L1_WAYS);
      tlic_pkg::CACHE_L1I: set_base = IW'(I_BASE) + IW'(a[4:3]) * IW'(L1_WAYS);
      tlic_pkg::CACHE_L2:  set_base = IW'(L2_BASE) + IW'(a[5:3]) * IW'(L2_WAYS);
      default:             set_base = IW'(L3_BASE) + IW'(a[7:4]) * IW'(L3_WAYS);
    endcase
  endfunction

  function automatic logic [TW-1:0] tag_of(input tlic_pkg::cache_e c,
                                           input logic [ADDR_WIDTH-1:0] a);
    unique case (c)
      tlic_pkg::CACHE_L1D, tlic_pkg::CACHE_L1I: tag_of = a[ADDR_WIDTH-1:5];
      tlic_pkg::CACHE_L2:  tag_of = TW'(a[ADDR_WIDTH-1:6]);
      default:             tag_of = TW'(a[ADDR_WIDTH-1:8]);
    endcase
  endfunction

  function automatic logic [WCW-1:0] ways_of(input tlic_pkg::cache_e c);
    unique case (c)
      tlic_pkg::CACHE_L1D, tlic_pkg::CACHE_L1I: ways_of = WCW'(L1_WAYS);
      tlic_pkg::CACHE_L2:  ways_of = WCW'(L2_WAYS);
      default:             ways_of = WCW'(L3_WAYS);
    endcase
  endfunction

  // Control state
  logic [4:0]      state_q, state_d, ret_q, ret_d, inv_ret_q, inv_ret_d, wb_ret_q, wb_ret_d;
  logic [NENT-1:0] valid_q, valid_d;
  logic [SW-1:0]   use_clk_q, use_clk_d;
  logic [WCW-1:0]  iss_q, iss_d;
  logic            ev_v_q, ev_v_d;
  logic            half_q, half_d;
  logic            second_q, second_d;

  // Item context and walk results
  logic [1:0]            op_q, op_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d, inv_addr_q, inv_addr_d, wb_addr_q, wb_addr_d;
  logic [ADDR_WIDTH-1:0] pair_q, pair_d;
  logic                  store_q, store_d, instr_q, instr_d, wb_l3_q, wb_l3_d;
  logic                  wb2_hit_q, wb2_hit_d, vdirty_q, vdirty_d;
  logic [IW-1:0]         vict_idx_q, vict_idx_d;
  logic [IW-1:0]         scan_base_q, scan_base_d;
  logic [WCW-1:0]        scan_w_q, scan_w_d, ev_way_q, ev_way_d;
  logic [TW-1:0]         scan_tag_q, scan_tag_d;
  logic                  rv_q, rv_d;
  logic                  m_found_q, m_found_d, m_dirty_q, m_dirty_d;
  logic [IW-1:0]         m_idx_q, m_idx_d;
  logic                  i_found_q, i_found_d;
  logic [IW-1:0]         i_idx_q, i_idx_d, lru_idx_q, lru_idx_d;
  logic [SW-1:0]         lru_stamp_q, lru_stamp_d;
  logic [TW-1:0]         lru_tag_q, lru_tag_d;
  logic                  lru_dirty_q, lru_dirty_d;

  // Per-access tally
  logic       t_l1_hit_q, t_l1_hit_d, t_l1_ev_q, t_l1_ev_d;
  logic [3:0] t_l2_hits_q, t_l2_hits_d, t_l3_hits_q, t_l3_hits_d;
  logic       t_l2_miss_q, t_l2_miss_d, t_l2_ev_q, t_l2_ev_d;
  logic       t_l3_miss_q, t_l3_miss_d, t_l3_ev_q, t_l3_ev_d;

  // Walk launch and entry update strobes
  logic                  call_en;
  tlic_pkg::cache_e      call_c;
  logic [ADDR_WIDTH-1:0] call_a;
  logic [4:0]            call_ret;
  logic                  wr_en, wr_dirty, v_set, v_clr;
  logic [IW-1:0]         wr_idx, v_idx;
  logic [TW-1:0]         wr_tag;

  logic [IW-1:0]         rd_idx, ev_idx;
  logic [EW-1:0]         ram_rdata;
  logic                  r_dirty;
  logic [TW-1:0]         r_tag;
  logic [SW-1:0]         r_stamp;
  logic [ADDR_WIDTH-1:0] sub_addr;
  tlic_pkg::cache_e      side_c;
  logic                  modify_first;

  assign rd_idx   = scan_base_q + IW'(iss_q);
  assign ev_idx   = scan_base_q + IW'(ev_way_q);
  assign r_dirty  = ram_rdata[EW-1];
  assign r_tag    = ram_rdata[SW +: TW];
  assign r_stamp  = ram_rdata[SW-1:0];
  assign sub_addr = {pair_q[ADDR_WIDTH-1:4], half_q, 3'b000};
  assign side_c   = instr_q ? tlic_pkg::CACHE_L1I : tlic_pkg::CACHE_L1D;
  assign modify_first = (op_q == tlic_pkg::OP_MODIFY) && !second_q;

  tlic_ram #(
    .WIDTH(EW),
    .DEPTH(NENT)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_idx),
    .wdata_i({wr_dirty, wr_tag, use_clk_q + 64'd1}),
    .raddr_i(rd_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;  ret_d = ret_q;  inv_ret_d = inv_ret_q;  wb_ret_d = wb_ret_q;
    valid_d = valid_q;  use_clk_d = use_clk_q;
    iss_d = iss_q;  ev_v_d = 1'b0;  half_d = half_q;  second_d = second_q;
    op_d = op_q;  addr_d = addr_q;  inv_addr_d = inv_addr_q;  wb_addr_d = wb_addr_q;
    pair_d = pair_q;  store_d = store_q;  instr_d = instr_q;  wb_l3_d = wb_l3_q;
    wb2_hit_d = wb2_hit_q;  vdirty_d = vdirty_q;  vict_idx_d = vict_idx_q;
    scan_base_d = scan_base_q;  scan_w_d = scan_w_q;  scan_tag_d = scan_tag_q;
    ev_way_d = ev_way_q;  rv_d = rv_q;
    m_found_d = m_found_q;  m_dirty_d = m_dirty_q;  m_idx_d = m_idx_q;
    i_found_d = i_found_q;  i_idx_d = i_idx_q;
    lru_idx_d = lru_idx_q;  lru_stamp_d = lru_stamp_q;
    lru_tag_d = lru_tag_q;  lru_dirty_d = lru_dirty_q;
    t_l1_hit_d = t_l1_hit_q;  t_l1_ev_d = t_l1_ev_q;
    t_l2_hits_d = t_l2_hits_q;  t_l2_miss_d = t_l2_miss_q;  t_l2_ev_d = t_l2_ev_q;
    t_l3_hits_d = t_l3_hits_q;  t_l3_miss_d = t_l3_miss_q;  t_l3_ev_d = t_l3_ev_q;
    call_en = 1'b0;  call_c = side_c;  call_a = addr_q;  call_ret = S_IDLE;
    wr_en = 1'b0;  wr_idx = m_idx_q;  wr_dirty = 1'b0;  wr_tag = '0;
    v_set = 1'b0;  v_clr = 1'b0;  v_idx = m_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = op_i;
          addr_d   = addr_i;
          store_d  = (op_i == tlic_pkg::OP_STORE);
          instr_d  = (op_i == tlic_pkg::OP_IFETCH);
          second_d = 1'b0;
          state_d  = S_L1_LOOK;
        end
      end
      S_SCAN: begin
        // Issue one way per cycle; evaluate the way read the cycle before.
        if (iss_q < scan_w_q) begin
          iss_d    = iss_q + WCW'(1);
          ev_v_d   = 1'b1;
          ev_way_d = iss_q;
          rv_d     = valid_q[rd_idx];
        end
        if (ev_v_q) begin
          if (rv_q && (r_tag == scan_tag_q) && !m_found_q) begin
            m_found_d = 1'b1;
            m_idx_d   = ev_idx;
            m_dirty_d = r_dirty;
          end
          if (!rv_q && !i_found_q) begin
            i_found_d = 1'b1;
            i_idx_d   = ev_idx;
          end
          if ((ev_way_q == '0) || (r_stamp < lru_stamp_q)) begin
            lru_idx_d   = ev_idx;
            lru_stamp_d = r_stamp;
            lru_tag_d   = r_tag;
            lru_dirty_d = r_dirty;
          end
          if (ev_way_q == scan_w_q - WCW'(1)) begin
            state_d = ret_q;
          end
        end
      end
      S_L1_LOOK: begin
        t_l1_hit_d = 1'b0;  t_l1_ev_d = 1'b0;
        t_l2_hits_d = '0;  t_l2_miss_d = 1'b0;  t_l2_ev_d = 1'b0;
        t_l3_hits_d = '0;  t_l3_miss_d = 1'b0;  t_l3_ev_d = 1'b0;
        call_en  = 1'b1;
        call_ret = S_L1_LOOK_R;
      end
      S_L1_LOOK_R: begin
        if (m_found_q) begin
          wr_en      = 1'b1;
          wr_dirty   = m_dirty_q | store_q;
          wr_tag     = tag_of(side_c, addr_q);
          t_l1_hit_d = 1'b1;
          state_d    = S_EMIT;
        end else begin
          call_en  = 1'b1;
          call_c   = tlic_pkg::CACHE_L2;
          call_ret = S_L2_LOOK_R;
        end
      end
      S_L2_LOOK_R: begin
        if (m_found_q) begin
          wr_en       = 1'b1;
          wr_dirty    = m_dirty_q;
          wr_tag      = tag_of(tlic_pkg::CACHE_L2, addr_q);
          t_l2_hits_d = tlic_pkg::sat_inc(t_l2_hits_q);
          state_d     = S_L1_PICK;
        end else begin
          t_l2_miss_d = 1'b1;
          call_en     = 1'b1;
          call_c      = tlic_pkg::CACHE_L3;
          call_ret    = S_L3_LOOK_R;
        end
      end
      S_L3_LOOK_R: begin
        if (m_found_q) begin
          wr_en       = 1'b1;
          wr_dirty    = m_dirty_q;
          wr_tag      = tag_of(tlic_pkg::CACHE_L3, addr_q);
          t_l3_hits_d = tlic_pkg::sat_inc(t_l3_hits_q);
          state_d     = S_L2_PICK;
        end else begin
          t_l3_miss_d = 1'b1;
          if (i_found_q) begin
            wr_en   = 1'b1;
            wr_idx  = i_idx_q;
            wr_tag  = tag_of(tlic_pkg::CACHE_L3, addr_q);
            v_set   = 1'b1;
            v_idx   = i_idx_q;
            state_d = S_L2_PICK;
          end else begin
            // Evict the LRU L3 way: first drop both L2 halves it covers and their L1 copies.
            t_l3_ev_d  = 1'b1;
            vict_idx_d = lru_idx_q;
            pair_d     = {lru_tag_q[ADDR_WIDTH-9:0], addr_q[7:4], 4'b0000};
            half_d     = 1'b0;
            state_d    = S_PAIR;
          end
        end
      end
      S_PAIR: begin
        inv_addr_d = sub_addr;
        inv_ret_d  = S_PAIR_L2;
        state_d    = S_INV_D;
      end
      S_PAIR_L2: begin
        call_en  = 1'b1;
        call_c   = tlic_pkg::CACHE_L2;
        call_a   = sub_addr;
        call_ret = S_PAIR_L2R;
      end
      S_PAIR_L2R: begin
        state_d = S_PAIR_NEXT;
        if (m_found_q) begin
          v_clr = 1'b1;
          if (m_dirty_q) begin
            wb_addr_d = sub_addr;
            wb_l3_d   = 1'b1;
            wb_ret_d  = S_PAIR_NEXT;
            state_d   = S_WB;
          end
        end
      end
      S_PAIR_NEXT: begin
        if (!half_q) begin
          half_d  = 1'b1;
          state_d = S_PAIR;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = vict_idx_q;
          wr_tag  = tag_of(tlic_pkg::CACHE_L3, addr_q);
          v_set   = 1'b1;
          v_idx   = vict_idx_q;
          state_d = S_L2_PICK;
        end
      end
      S_L2_PICK: begin
        call_en  = 1'b1;
        call_c   = tlic_pkg::CACHE_L2;
        call_ret = S_L2_PICK_R;
      end
      S_L2_PICK_R: begin
        if (i_found_q) begin
          wr_en   = 1'b1;
          wr_idx  = i_idx_q;
          wr_tag  = tag_of(tlic_pkg::CACHE_L2, addr_q);
          v_set   = 1'b1;
          v_idx   = i_idx_q;
          state_d = S_L1_PICK;
        end else begin
          // Drop L1 copies of the victim; a dirty copy written back marks it dirty.
          t_l2_ev_d  = 1'b1;
          vict_idx_d = lru_idx_q;
          vdirty_d   = lru_dirty_q;
          wb2_hit_d  = 1'b0;
          inv_addr_d = {lru_tag_q[ADDR_WIDTH-7:0], addr_q[5:3], 3'b000};
          inv_ret_d  = S_L2_EV;
          state_d    = S_INV_D;
        end
      end
      S_L2_EV: begin
        state_d = S_L2_FILL;
        if (vdirty_q || wb2_hit_q) begin
          wb_addr_d = inv_addr_q;
          wb_l3_d   = 1'b1;
          wb_ret_d  = S_L2_FILL;
          state_d   = S_WB;
        end
      end
      S_L2_FILL: begin
        wr_en   = 1'b1;
        wr_idx  = vict_idx_q;
        wr_tag  = tag_of(tlic_pkg::CACHE_L2, addr_q);
        v_set   = 1'b1;
        v_idx   = vict_idx_q;
        state_d = S_L1_PICK;
      end
      S_L1_PICK: begin
        call_en  = 1'b1;
        call_ret = S_L1_PICK_R;
      end
      S_L1_PICK_R: begin
        if (i_found_q) begin
          wr_en    = 1'b1;
          wr_idx   = i_idx_q;
          wr_dirty = store_q;
          wr_tag   = tag_of(side_c, addr_q);
          v_set    = 1'b1;
          v_idx    = i_idx_q;
          state_d  = S_EMIT;
        end else begin
          t_l1_ev_d  = 1'b1;
          vict_idx_d = lru_idx_q;
          state_d    = S_L1_FILL;
          if (lru_dirty_q) begin
            wb_addr_d = {lru_tag_q[ADDR_WIDTH-6:0], addr_q[4:3], 3'b000};
            wb_l3_d   = 1'b0;
            wb_ret_d  = S_L1_FILL;
            state_d   = S_WB;
          end
        end
      end
      S_L1_FILL: begin
        wr_en    = 1'b1;
        wr_idx   = vict_idx_q;
        wr_dirty = store_q;
        wr_tag   = tag_of(side_c, addr_q);
        state_d  = S_EMIT;
      end
      S_INV_D: begin
        call_en  = 1'b1;
        call_c   = tlic_pkg::CACHE_L1D;
        call_a   = inv_addr_q;
        call_ret = S_INV_DR;
      end
      S_INV_DR: begin
        state_d = S_INV_I;
        if (m_found_q) begin
          v_clr = 1'b1;
          if (m_dirty_q) begin
            wb_addr_d = inv_addr_q;
            wb_l3_d   = 1'b0;
            wb_ret_d  = S_INV_I;
            state_d   = S_WB;
          end
        end
      end
      S_INV_I: begin
        call_en  = 1'b1;
        call_c   = tlic_pkg::CACHE_L1I;
        call_a   = inv_addr_q;
        call_ret = S_INV_IR;
      end
      S_INV_IR: begin
        v_clr   = m_found_q;
        state_d = inv_ret_q;
      end
      S_WB: begin
        call_en  = 1'b1;
        call_c   = wb_l3_q ? tlic_pkg::CACHE_L3 : tlic_pkg::CACHE_L2;
        call_a   = wb_addr_q;
        call_ret = S_WB_R;
      end
      S_WB_R: begin
        // A write-back that misses is dropped.
        if (m_found_q) begin
          wr_en    = 1'b1;
          wr_dirty = 1'b1;
          if (wb_l3_q) begin
            wr_tag      = tag_of(tlic_pkg::CACHE_L3, wb_addr_q);
            t_l3_hits_d = tlic_pkg::sat_inc(t_l3_hits_q);
          end else begin
            wr_tag      = tag_of(tlic_pkg::CACHE_L2, wb_addr_q);
            t_l2_hits_d = tlic_pkg::sat_inc(t_l2_hits_q);
            wb2_hit_d   = 1'b1;
          end
        end
        state_d = wb_ret_q;
      end
      S_EMIT: begin
        if (modify_first) begin
          second_d = 1'b1;
          store_d  = 1'b1;
          state_d  = S_L1_LOOK;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Launch a set walk.
    if (call_en) begin
      scan_base_d = set_base(call_c, call_a);
      scan_w_d    = ways_of(call_c);
      scan_tag_d  = tag_of(call_c, call_a);
      iss_d       = '0;
      m_found_d   = 1'b0;
      i_found_d   = 1'b0;
      ret_d       = call_ret;
      state_d     = S_SCAN;
    end

    // Every tag RAM write refreshes recency.
    if (wr_en) begin
      use_clk_d = use_clk_q + 64'd1;
    end
    if (v_set) begin
      valid_d[v_idx] = 1'b1;
    end else if (v_clr) begin
      valid_d[v_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      inv_ret_q <= S_IDLE;
      wb_ret_q  <= S_IDLE;
      valid_q   <= '0;
      use_clk_q <= '0;
      iss_q     <= '0;
      ev_v_q    <= 1'b0;
      half_q    <= 1'b0;
      second_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      inv_ret_q <= inv_ret_d;
      wb_ret_q  <= wb_ret_d;
      valid_q   <= valid_d;
      use_clk_q <= use_clk_d;
      iss_q     <= iss_d;
      ev_v_q    <= ev_v_d;
      half_q    <= half_d;
      second_q  <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    inv_addr_q  <= inv_addr_d;
    wb_addr_q   <= wb_addr_d;
    pair_q      <= pair_d;
    store_q     <= store_d;
    instr_q     <= instr_d;
    wb_l3_q     <= wb_l3_d;
    wb2_hit_q   <= wb2_hit_d;
    vdirty_q    <= vdirty_d;
    vict_idx_q  <= vict_idx_d;
    scan_base_q <= scan_base_d;
    scan_w_q    <= scan_w_d;
    scan_tag_q  <= scan_tag_d;
    ev_way_q    <= ev_way_d;
    rv_q        <= rv_d;
    m_found_q   <= m_found_d;
    m_dirty_q   <= m_dirty_d;
    m_idx_q     <= m_idx_d;
    i_found_q   <= i_found_d;
    i_idx_q     <= i_idx_d;
    lru_idx_q   <= lru_idx_d;
    lru_stamp_q <= lru_stamp_d;
    lru_tag_q   <= lru_tag_d;
    lru_dirty_q <= lru_dirty_d;
    t_l1_hit_q  <= t_l1_hit_d;
    t_l1_ev_q   <= t_l1_ev_d;
    t_l2_hits_q <= t_l2_hits_d;
    t_l2_miss_q <= t_l2_miss_d;
    t_l2_ev_q   <= t_l2_ev_d;
    t_l3_hits_q <= t_l3_hits_d;
    t_l3_miss_q <= t_l3_miss_d;
    t_l3_ev_q   <= t_l3_ev_d;
  end

  // Result ports: one strobe per access step.
  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = (state_q == S_EMIT);
  assign instr_side_o    = instr_q;
  assign l1_hit_o        = t_l1_hit_q;
  assign l1_evict_o      = t_l1_ev_q;
  assign l2_hits_added_o = t_l2_hits_q;
  assign l2_miss_o       = t_l2_miss_q;
  assign l2_evict_o      = t_l2_ev_q;
  assign l3_hits_added_o = t_l3_hits_q;
  assign l3_miss_o       = t_l3_miss_q;
  assign l3_evict_o      = t_l3_ev_q;
  assign last_o          = !modify_first;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (iss_q <= scan_w_q))
    else $error("set walk issued past the last way");

  a_hit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && l1_hit_o) |-> (!l1_evict_o && !l2_miss_o &&
      (l2_hits_added_o == 4'd0) && (l3_hits_added_o == 4'd0)))
    else $error("L1 hit reported activity below L1");

  a_l3_miss_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && l3_miss_o) |-> l2_miss_o)
    else $error("L3 miss without L2 miss");

  a_l3_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && l3_evict_o) |-> l3_miss_o)
    else $error("L3 eviction without L3 miss");

  a_clock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (use_clk_q != $past(use_clk_q)) |-> (use_clk_q == $past(use_clk_q) + 64'd1))
    else $error("use clock moved by more than one");

endmodule
`default_nettype wire

// ----- tb/three_level_inclusive_cache_model_top_test.sv -----
// Self-checking testbench for the three-level inclusive cache tag model.
`timescale 1ns / 1ps
module three_level_inclusive_cache_model_top_test;

  // Flat layout shared by the line store and the recency stamps.
  localparam int L1W = 2, L2W = 4, L3W = 8;
  localparam int D_OFS = 0, I_OFS = 8, L2_OFS = 16, L3_OFS = 48, N_LINES = 176;

  typedef struct {
    bit          valid;
    bit          dirty;
    logic [63:0] tag;
  } line_t;

  typedef struct packed {
    logic       instr_side;
    logic       l1_hit;
    logic       l1_evict;
    logic [3:0] l2_hits;
    logic       l2_miss;
    logic       l2_evict;
    logic [3:0] l3_hits;
    logic       l3_miss;
    logic       l3_evict;
    logic       last;
  } outcome_t;

  typedef struct {
    logic [1:0]  op;
    logic [47:0] addr;
    bit          drain;
  } access_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  op_i = tlic_pkg::OP_LOAD;
  logic [47:0] addr_i = '0;
  logic        busy, result_valid_o, instr_side_o, l1_hit_o, l1_evict_o;
  logic        l2_miss_o, l2_evict_o, l3_miss_o, l3_evict_o, last_o;
  logic [3:0]  l2_hits_added_o, l3_hits_added_o;

  three_level_inclusive_cache_model_top dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .addr_i, .result_valid_o,
    .instr_side_o, .l1_hit_o, .l1_evict_o, .l2_hits_added_o, .l2_miss_o,
    .l2_evict_o, .l3_hits_added_o, .l3_miss_o, .l3_evict_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Tag and recency state of the predicted cache.
  line_t       lines[N_LINES];
  logic [63:0] stamps[N_LINES];
  logic [63:0] use_count = '0;
  int t_l1hit, t_l1ev, t_l2h, t_l2m, t_l2ev, t_l3h, t_l3m, t_l3ev;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  int       accepted = 0;
  int       errors = 0;

  initial begin
    foreach (lines[i]) begin
      lines[i] = '{0, 0, '0};
      stamps[i] = '0;
    end
  end

  function automatic void refresh(int idx);
    use_count++;
    stamps[idx] = use_count;
  endfunction

  function automatic int find_line(int base, int ways, logic [63:0] tag);
    for (int i = 0; i < ways; i++)
      if (lines[base + i].valid && lines[base + i].tag == tag) return i;
    return -1;
  endfunction

  // Lowest invalid way first, otherwise the oldest stamp (lowest way on a tie).
  function automatic int victim_way(int base, int ways, output bit evicting);
    int oldest;
    oldest = 0;
    for (int i = 0; i < ways; i++)
      if (!lines[base + i].valid) begin
        evicting = 0;
        return i;
      end
    evicting = 1;
    for (int i = 1; i < ways; i++)
      if (stamps[base + i] < stamps[base + oldest]) oldest = i;
    return oldest;
  endfunction

  function automatic void writeback_l2(logic [63:0] a);
    int base, w;
    base = L2_OFS + int'((a >> 3) & 7) * L2W;
    w = find_line(base, L2W, a >> 6);
    if (w >= 0) begin
      lines[base + w].dirty = 1;
      refresh(base + w);
      t_l2h++;
    end
  endfunction

  function automatic void writeback_l3(logic [63:0] a);
    int base, w;
    base = L3_OFS + int'((a >> 4) & 15) * L3W;
    w = find_line(base, L3W, a >> 8);
    if (w >= 0) begin
      lines[base + w].dirty = 1;
      refresh(base + w);
      t_l3h++;
    end
  endfunction

  function automatic void drop_l1(int idx, logic [63:0] set, logic [63:0] tag);
    if (lines[idx].valid && lines[idx].tag == tag) begin
      if (lines[idx].dirty) begin
        writeback_l2((tag << 5) | (set << 3));
        lines[idx].dirty = 0;
      end
      lines[idx].valid = 0;
    end
  endfunction

  function automatic void purge_l1(logic [63:0] a);
    logic [63:0] set;
    set = (a >> 3) & 3;
    for (int i = 0; i < L1W; i++) begin
      drop_l1(D_OFS + int'(set) * L1W + i, set, a >> 5);
      drop_l1(I_OFS + int'(set) * L1W + i, set, a >> 5);
    end
  endfunction

  // Drop both 8-byte L2 halves of a 16-byte L3 line, and their L1 copies.
  function automatic void purge_l2_pair(logic [63:0] a);
    logic [63:0] sub, set, tag;
    int idx;
    for (int half = 0; half < 2; half++) begin
      sub = (a & ~64'hF) + 64'(half * 8);
      set = (sub >> 3) & 7;
      tag = sub >> 6;
      purge_l1(sub);
      for (int i = 0; i < L2W; i++) begin
        idx = L2_OFS + int'(set) * L2W + i;
        if (lines[idx].valid && lines[idx].tag == tag) begin
          if (lines[idx].dirty) begin
            writeback_l3((tag << 6) | (set << 3));
            lines[idx].dirty = 0;
          end
          lines[idx].valid = 0;
        end
      end
    end
  endfunction

  function automatic void fill_l3(logic [63:0] a);
    logic [63:0] set;
    int base, w;
    bit ev;
    set = (a >> 4) & 15;
    base = L3_OFS + int'(set) * L3W;
    w = find_line(base, L3W, a >> 8);
    if (w >= 0) begin
      t_l3h++;
      refresh(base + w);
      return;
    end
    t_l3m = 1;
    w = victim_way(base, L3W, ev);
    if (ev) begin
      purge_l2_pair((lines[base + w].tag << 8) | (set << 4));
      t_l3ev = 1;
    end
    lines[base + w] = '{1, 0, a >> 8};
    refresh(base + w);
  endfunction

  function automatic void fill_l2(logic [63:0] a);
    logic [63:0] set, va;
    int base, w;
    bit ev;
    set = (a >> 3) & 7;
    base = L2_OFS + int'(set) * L2W;
    w = find_line(base, L2W, a >> 6);
    if (w >= 0) begin
      t_l2h++;
      refresh(base + w);
      return;
    end
    t_l2m = 1;
    fill_l3(a);
    w = victim_way(base, L2W, ev);
    if (ev) begin
      va = (lines[base + w].tag << 6) | (set << 3);
      purge_l1(va);
      if (lines[base + w].dirty) begin
        writeback_l3(va);
        lines[base + w].dirty = 0;
      end
      t_l2ev = 1;
    end
    lines[base + w] = '{1, 0, a >> 6};
    refresh(base + w);
  endfunction

  // One access step; returns the counter increments it causes.
  function automatic outcome_t cache_access(logic [63:0] a, bit wr, bit ifetch, bit fin);
    logic [63:0] set;
    int base, w;
    bit ev;
    outcome_t r;
    t_l1hit = 0; t_l1ev = 0; t_l2h = 0; t_l2m = 0;
    t_l2ev = 0; t_l3h = 0; t_l3m = 0; t_l3ev = 0;
    set = (a >> 3) & 3;
    base = (ifetch ? I_OFS : D_OFS) + int'(set) * L1W;
    w = find_line(base, L1W, a >> 5);
    if (w >= 0) begin
      refresh(base + w);
      if (wr) lines[base + w].dirty = 1;
      t_l1hit = 1;
    end else begin
      fill_l2(a);
      w = victim_way(base, L1W, ev);
      if (ev) begin
        if (lines[base + w].dirty) begin
          writeback_l2((lines[base + w].tag << 5) | (set << 3));
          lines[base + w].dirty = 0;
        end
        t_l1ev = 1;
      end
      lines[base + w] = '{1, wr, a >> 5};
      refresh(base + w);
    end
    r.instr_side = ifetch;
    r.l1_hit     = t_l1hit[0];
    r.l1_evict   = t_l1ev[0];
    r.l2_hits    = (t_l2h > 15) ? tlic_pkg::HITS_MAX : 4'(t_l2h);
    r.l2_miss    = t_l2m[0];
    r.l2_evict   = t_l2ev[0];
    r.l3_hits    = (t_l3h > 15) ? tlic_pkg::HITS_MAX : 4'(t_l3h);
    r.l3_miss    = t_l3m[0];
    r.l3_evict   = t_l3ev[0];
    r.last       = fin;
    return r;
  endfunction

  function automatic void predict_access(logic [1:0] op, logic [47:0] addr);
    logic [63:0] a;
    a = 64'(addr);
    if (op == tlic_pkg::OP_MODIFY) begin
      expected_outcomes.push_back(cache_access(a, 0, 0, 0));
      expected_outcomes.push_back(cache_access(a, 1, 0, 1));
    end else begin
      expected_outcomes.push_back(cache_access(a, op == tlic_pkg::OP_STORE,
                                               op == tlic_pkg::OP_IFETCH, 1));
    end
  endfunction

  // Driver: predict on acceptance, then present the next item or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    int idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_access(op_i, addr_i);
        accepted++;
      end
      if (!start || !busy) begin
        idle_pct = (accepted < 450) ? 21 : (accepted < 900) ? 73 : 0;
        if (pending_accesses.size() == 0 ||
            (pending_accesses[0].drain && expected_outcomes.size() != 0) ||
            $urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
        end else begin
          start  <= 1'b1;
          op_i   <= pending_accesses[0].op;
          addr_i <= pending_accesses[0].addr;
          void'(pending_accesses.pop_front());
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && result_valid_o) begin
      got = {instr_side_o, l1_hit_o, l1_evict_o, l2_hits_added_o, l2_miss_o,
             l2_evict_o, l3_hits_added_o, l3_miss_o, l3_evict_o, last_o};
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  function automatic void enqueue(logic [1:0] op, logic [47:0] addr, bit drain = 0);
    pending_accesses.push_back('{op, addr, drain});
  endfunction

  initial begin
    logic [47:0] bases[4];
    int pick;
    // Directed: extremes, every op, dirty evictions with write-backs at each level.
    enqueue(tlic_pkg::OP_LOAD, '0);
    enqueue(tlic_pkg::OP_STORE, '0);
    enqueue(tlic_pkg::OP_MODIFY, 48'hFFFF_FFFF_FFFF);
    enqueue(tlic_pkg::OP_IFETCH, 48'hFFFF_FFFF_FFFF);
    enqueue(tlic_pkg::OP_IFETCH, '0);
    enqueue(tlic_pkg::OP_LOAD, 48'h0000_0000_0008);
    // Same L3 set with nine tags forces L3 eviction and back-invalidation.
    for (int i = 1; i <= 9; i++) enqueue(tlic_pkg::OP_STORE, 48'(i) << 8);
    // Same L2/L1 set walks force L2 and L1 victims, dirty ones among them.
    for (int i = 0; i < 6; i++) enqueue(tlic_pkg::OP_MODIFY, 48'(i) << 6 | 48'h5);
    enqueue(tlic_pkg::OP_IFETCH, 48'h0000_0000_0040);
    enqueue(tlic_pkg::OP_LOAD, 48'hAAAA_AAAA_AAAA, 1);
    enqueue(tlic_pkg::OP_STORE, 48'h5555_5555_5555);

    bases[0] = '0;
    bases[1] = 48'hFFFF_FFFF_F000;
    bases[2] = {$urandom, 16'h0} & ~48'hFFF;
    bases[3] = {16'($urandom), $urandom} & ~48'hFFF;
    // Random: mostly a small footprint to get hits and conflicts, some noise.
    for (int n = 0; n < 1300; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        enqueue(2'($urandom), {16'($urandom), $urandom});
      else if (pick < 55)
        enqueue(2'($urandom), bases[$urandom_range(0, 3)] | 48'($urandom_range(0, 511)));
      else
        enqueue(2'($urandom), bases[$urandom_range(0, 3)] | 48'($urandom_range(0, 4095)),
                n == 600);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_accesses.size() == 0);
    @(posedge clk_i);
    while (start || expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tlic_pkg.sv
rtl/tlic_ram.sv
rtl/three_level_inclusive_cache_model_top.sv
tb/three_level_inclusive_cache_model_top_test.sv
